### hw/rtl/tiled_texture_texel_decoder_unit_defines.svh
// assertion macros of the texel decoder, used by the merge stage
`ifndef TILED_TEXTURE_TEXEL_DECODER_UNIT_DEFINES_SVH
`define TILED_TEXTURE_TEXEL_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define TTD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("texel decoder assertion failed");
`define TTD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("texel decoder assertion failed");
`else
`define TTD_ASSERT_IMP(label, clk, rst, ante, cons)
`define TTD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/ttd_pkg.sv
// types, codes and color helpers of the texel decoder
package ttd_pkg;

   localparam int PaletteEntries = 16384;
   localparam int PalAw = $clog2(PaletteEntries);
   localparam int MaxDim = 1024;
   localparam int DimW = 11;
   localparam int CoordW = 10;
   localparam int Lanes = 16;
   localparam int LaneW = 4;

   localparam logic [3:0] FMT_I4     = 4'd0;
   localparam logic [3:0] FMT_I8     = 4'd1;
   localparam logic [3:0] FMT_IA4    = 4'd2;
   localparam logic [3:0] FMT_IA8    = 4'd3;
   localparam logic [3:0] FMT_RGB565 = 4'd4;
   localparam logic [3:0] FMT_RGB5A3 = 4'd5;
   localparam logic [3:0] FMT_RGBA8  = 4'd6;
   localparam logic [3:0] FMT_C4     = 4'd8;
   localparam logic [3:0] FMT_C8     = 4'd9;
   localparam logic [3:0] FMT_C14X2  = 4'd10;
   localparam logic [3:0] FMT_CMPR   = 4'd14;

   localparam logic [1:0] PAL_IA8    = 2'd0;
   localparam logic [1:0] PAL_RGB565 = 2'd1;

   localparam logic OP_TEXTURE = 1'b0;
   localparam logic OP_PALETTE = 1'b1;

   localparam logic [1:0] CSR_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_FORMAT  = 2'd2;
   localparam logic [1:0] CSR_PALFMT  = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [63:0] data_word;
      logic [13:0] entry_index;
      logic [15:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [9:0] texel_x;
      logic [9:0] texel_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } color_type;

   typedef color_type [3:0] cmpr_pal_type;

   typedef struct packed {
      logic [63:0]       word;
      logic [63:0]       ar;
      logic [3:0]        fmt;
      logic [CoordW-1:0] bx;
      logic [CoordW-1:0] by;
      logic [2:0]        wib;
      cmpr_pal_type      cmpr;
      logic [DimW-1:0]   limit_x;
      logic [DimW-1:0]   limit_y;
   } job_type;

   typedef struct packed {
      logic              valid;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      color_type         color;
      logic              pal_use;
      logic [PalAw-1:0]  pal_idx;
   } lane_type;

   typedef struct packed {
      logic             load;
      logic             pal_we;
      logic [PalAw-1:0] pal_idx;
      logic [15:0]      pal_val;
      logic [1:0]       pal_fmt;
   } merge_ctl_type;

   typedef struct packed {
      logic busy;
      logic finishing;
   } merge_sts_type;

   function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] v);
      if (v == '0) return DimW'(1);
      if (v > DimW'(MaxDim)) return DimW'(MaxDim);
      return v;
   endfunction

   function automatic logic [7:0] x5(logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] x6(logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [7:0] x4(logic [3:0] v);
      return {v, v};
   endfunction

   function automatic logic [7:0] x3(logic [2:0] v);
      return {v, v, v[2:1]};
   endfunction

   function automatic color_type col565(logic [15:0] c);
      return '{r: x5(c[15:11]), g: x6(c[10:5]), b: x5(c[4:0]), a: 8'hFF};
   endfunction

   function automatic color_type col5a3(logic [15:0] c);
      if (c[15]) return '{r: x5(c[14:10]), g: x5(c[9:5]), b: x5(c[4:0]), a: 8'hFF};
      return '{r: x4(c[11:8]), g: x4(c[7:4]), b: x4(c[3:0]), a: x3(c[14:12])};
   endfunction

   function automatic color_type colia8(logic [15:0] c);
      return '{r: c[7:0], g: c[7:0], b: c[7:0], a: c[15:8]};
   endfunction

   function automatic color_type pal_color(logic [15:0] c, logic [1:0] pf);
      if (pf == PAL_IA8) return colia8(c);
      if (pf == PAL_RGB565) return col565(c);
      return col5a3(c);
   endfunction

   // floor(v/3) by reciprocal, exact below 768
   function automatic logic [7:0] div3(logic [9:0] v);
      logic [19:0] prod;
      prod = 20'(v) * 20'd683;
      return prod[18:11];
   endfunction

   function automatic logic [7:0] third(logic [7:0] a, logic [7:0] b);
      return div3(({2'b0, a} << 1) + {2'b0, b});
   endfunction

   function automatic logic [7:0] avg(logic [7:0] a, logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

   function automatic cmpr_pal_type cmpr_palette(logic [15:0] c0, logic [15:0] c1);
      cmpr_pal_type p;
      logic         gt;
      gt = c0 > c1;
      p[0] = col565(c0);
      p[1] = col565(c1);
      p[2].r = gt ? third(p[0].r, p[1].r) : avg(p[0].r, p[1].r);
      p[2].g = gt ? third(p[0].g, p[1].g) : avg(p[0].g, p[1].g);
      p[2].b = gt ? third(p[0].b, p[1].b) : avg(p[0].b, p[1].b);
      p[3].r = gt ? third(p[1].r, p[0].r) : p[2].r;
      p[3].g = gt ? third(p[1].g, p[0].g) : p[2].g;
      p[3].b = gt ? third(p[1].b, p[0].b) : p[2].b;
      p[2].a = 8'hFF;
      p[3].a = gt ? 8'hFF : 8'h00;
      return p;
   endfunction

endpackage

### hw/rtl/ttd_lane.sv
// one decode lane: color, palette index and position of one texel slot
module ttd_lane (
   input  ttd_pkg::job_type              job,
   input  logic [ttd_pkg::LaneW-1:0]     lane_num,
   output ttd_pkg::lane_type             lane
);

   logic [3:0]  k;
   logic [7:0]  byte_v;
   logic [3:0]  nib;
   logic [15:0] half_v;
   logic [15:0] ar_v;
   logic [7:0]  row_v;
   logic [1:0]  sel;
   logic        ok;
   logic [3:0]  x_off;
   logic [3:0]  y_off;
   logic [ttd_pkg::DimW-1:0] x_full;
   logic [ttd_pkg::DimW-1:0] y_full;
   ttd_pkg::color_type color;
   logic        pal_use;
   logic [ttd_pkg::PalAw-1:0] pal_idx;

   always_comb begin
      k = lane_num;
      byte_v = '0;
      nib = '0;
      half_v = job.word[16*(3-int'(k[1:0])) +: 16];
      ar_v = job.ar[16*(3-int'(k[1:0])) +: 16];
      row_v = job.word[8*(3-int'(k[3:2])) +: 8];
      sel = row_v[2*(3-int'(k[1:0])) +: 2];
      ok = 1'b0;
      x_off = '0;
      y_off = '0;
      color = '0;
      pal_use = 1'b0;
      pal_idx = '0;
      case (job.fmt)
         ttd_pkg::FMT_I4, ttd_pkg::FMT_C4: begin
            byte_v = job.word[8*(7-int'(k[3:1])) +: 8];
            nib = k[0] ? byte_v[3:0] : byte_v[7:4];
            ok = 1'b1;
            x_off = {1'b0, k[2:0]};
            y_off = {1'b0, job.wib[1:0], k[3]};
            color = '{r: ttd_pkg::x4(nib), g: ttd_pkg::x4(nib), b: ttd_pkg::x4(nib),
                      a: ttd_pkg::x4(nib)};
            pal_use = (job.fmt == ttd_pkg::FMT_C4);
            pal_idx = ttd_pkg::PalAw'(nib);
         end
         ttd_pkg::FMT_I8, ttd_pkg::FMT_IA4, ttd_pkg::FMT_C8: begin
            byte_v = job.word[8*(7-int'(k[2:0])) +: 8];
            ok = !k[3];
            x_off = {1'b0, k[2:0]};
            y_off = {2'b0, job.wib[1:0]};
            if (job.fmt == ttd_pkg::FMT_I8) begin
               color = '{r: byte_v, g: byte_v, b: byte_v, a: byte_v};
            end else begin
               color = '{r: ttd_pkg::x4(byte_v[3:0]), g: ttd_pkg::x4(byte_v[3:0]),
                         b: ttd_pkg::x4(byte_v[3:0]), a: ttd_pkg::x4(byte_v[7:4])};
            end
            pal_use = (job.fmt == ttd_pkg::FMT_C8);
            pal_idx = ttd_pkg::PalAw'(byte_v);
         end
         ttd_pkg::FMT_IA8, ttd_pkg::FMT_RGB565, ttd_pkg::FMT_RGB5A3,
         ttd_pkg::FMT_C14X2: begin
            ok = (k[3:2] == 2'b00);
            x_off = {2'b0, k[1:0]};
            y_off = {2'b0, job.wib[1:0]};
            if (job.fmt == ttd_pkg::FMT_IA8) color = ttd_pkg::colia8(half_v);
            else if (job.fmt == ttd_pkg::FMT_RGB565) color = ttd_pkg::col565(half_v);
            else color = ttd_pkg::col5a3(half_v);
            pal_use = (job.fmt == ttd_pkg::FMT_C14X2);
            pal_idx = half_v[ttd_pkg::PalAw-1:0];
         end
         ttd_pkg::FMT_RGBA8: begin
            // alpha/red words only fill the buffer
            ok = job.wib[2] && (k[3:2] == 2'b00);
            x_off = {2'b0, k[1:0]};
            y_off = {2'b0, job.wib[1:0]};
            color = '{r: ar_v[7:0], g: half_v[15:8], b: half_v[7:0], a: ar_v[15:8]};
         end
         ttd_pkg::FMT_CMPR: begin
            ok = 1'b1;
            x_off = {1'b0, job.wib[0], k[1:0]};
            y_off = {1'b0, job.wib[1], k[3:2]};
            color = job.cmpr[sel];
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      x_full = {1'b0, job.bx} + ttd_pkg::DimW'(x_off);
      y_full = {1'b0, job.by} + ttd_pkg::DimW'(y_off);
      lane.valid = ok && (x_full < job.limit_x) && (y_full < job.limit_y);
      lane.x = x_full[ttd_pkg::CoordW-1:0];
      lane.y = y_full[ttd_pkg::CoordW-1:0];
      lane.color = color;
      lane.pal_use = pal_use;
      lane.pal_idx = pal_idx;
   end

endmodule

### hw/rtl/ttd_merge.sv
// picks lane results in order, looks up the palette and registers the output
`include "tiled_texture_texel_decoder_unit_defines.svh"

module ttd_merge (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ttd_pkg::merge_ctl_type                  ctl,
   input  ttd_pkg::lane_type [ttd_pkg::Lanes-1:0]  lanes,
   output ttd_pkg::merge_sts_type                  sts,
   input  logic                                    rsp_ready,
   output logic                                    rsp_valid,
   output ttd_pkg::rsp_type                        rsp_data
);

   logic [15:0] pal_mem [ttd_pkg::PaletteEntries];
   logic [15:0] rd_ff;

   logic [ttd_pkg::Lanes-1:0] pend_ff, pend_in;
   logic [ttd_pkg::Lanes-1:0] lane_ok, eff, pick, rest;
   logic [ttd_pkg::LaneW-1:0] sel;
   logic                      out_adv, seq_adv;

   logic              s2_valid_ff;
   ttd_pkg::lane_type s2_lane_ff;
   logic              s2_last_ff;

   logic             rsp_valid_ff;
   ttd_pkg::rsp_type rsp_data_ff;
   ttd_pkg::color_type out_color;

   always_comb begin
      for (int i = 0; i < ttd_pkg::Lanes; i++) lane_ok[i] = lanes[i].valid;
      eff = pend_ff & lane_ok;
      // lowest pending lane goes first
      pick = eff & (~eff + ttd_pkg::Lanes'(1));
      rest = eff & ~pick;
      sel = '0;
      for (int i = 0; i < ttd_pkg::Lanes; i++) begin
         if (pick[i]) sel = ttd_pkg::LaneW'(i);
      end
      out_adv = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
      seq_adv = (eff != '0) && (!s2_valid_ff || out_adv);
      sts.busy = (eff != '0);
      sts.finishing = seq_adv && (rest == '0);
      if (ctl.load) pend_in = '1;
      else if (seq_adv) pend_in = pend_ff & ~pick;
      else pend_in = pend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) pend_ff <= '0;
      else pend_ff <= pend_in;
   end

   // read before write keeps the old entry for the last lookup of a request
   always_ff @(posedge clock) begin
      if (ctl.pal_we) pal_mem[ctl.pal_idx] <= ctl.pal_val;
      if (seq_adv) rd_ff <= pal_mem[lanes[sel].pal_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (seq_adv) begin
         s2_valid_ff <= 1'b1;
      end else if (out_adv) begin
         s2_valid_ff <= 1'b0;
      end
      if (seq_adv) begin
         s2_lane_ff <= lanes[sel];
         s2_last_ff <= (rest == '0);
      end
   end

   always_comb begin
      out_color = s2_lane_ff.pal_use ? ttd_pkg::pal_color(rd_ff, ctl.pal_fmt)
                                     : s2_lane_ff.color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_adv) begin
         rsp_data_ff.texel_x <= s2_lane_ff.x;
         rsp_data_ff.texel_y <= s2_lane_ff.y;
         rsp_data_ff.red <= out_color.r;
         rsp_data_ff.green <= out_color.g;
         rsp_data_ff.blue <= out_color.b;
         rsp_data_ff.alpha <= out_color.a;
         rsp_data_ff.last <= s2_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `TTD_ASSERT_IMP(a_load_when_free, clock, reset, ctl.load, !sts.busy || sts.finishing)
   `TTD_ASSERT_IMP(a_pick_onehot, clock, reset, seq_adv, $onehot(pick))
   `TTD_ASSERT_NXT(a_pend_shrinks, clock, reset, !ctl.load, (pend_ff & ~$past(pend_ff)) == '0)

endmodule

### hw/rtl/tiled_texture_texel_decoder_unit.sv
// top level of the block-tiled texture texel decoder
//
// req_ channel: one request per cycle; operation selects a texture word or a palette
// entry write. rsp_ channel: one texel per cycle with x, y, RGBA and last, which marks
// the final texel of a texture word. csr_: write enable, index, data; writing any
// register restarts the texture at block origin, and must be done only while idle;
// the block itself does not enforce this. A texture word is held in a request register
// and decoded by sixteen lanes at once; a merge stage sends the in-bounds texels out
// one a cycle, looking up the palette memory for each palette texel. Texels pass the
// request register, merge stage and output register. A word yields up to sixteen
// texels (I4, C4 and CMPR); a palette write is done as it is taken. The next request
// is taken in the cycle the last texel of the current one enters the merge stage.
// When rsp_ready is low a full output register holds, and behind it the merge stage
// and the request register; req_ready stays low while the request register has
// texels left. Reset clears the position, the pipeline and the registers to width 1,
// height 1, format I4, palette IA8; palette contents are undefined until written.
module tiled_texture_texel_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ttd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ttd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [ttd_pkg::DimW-1:0]           csr_wdata
);

   logic [ttd_pkg::DimW-1:0] width_ff, height_ff;
   logic [3:0]               fmt_ff;
   logic [1:0]               pfmt_ff;
   logic [ttd_pkg::DimW-1:0] limit_x, limit_y;

   logic [ttd_pkg::CoordW-1:0] col_ff, col_in, row_ff, row_in;
   logic [2:0]                 wib_ff, wib_in;
   logic [63:0]                ar_buf_ff [4];

   ttd_pkg::job_type job_ff;
   ttd_pkg::lane_type [ttd_pkg::Lanes-1:0] lanes;
   ttd_pkg::merge_ctl_type ctl;
   ttd_pkg::merge_sts_type sts;

   logic acc, tex_acc, pal_acc, last_word;
   logic [3:0] bw, bh;
   logic [ttd_pkg::DimW-1:0] col_sum, row_sum;

   assign limit_x = ttd_pkg::eff_dim(width_ff);
   assign limit_y = ttd_pkg::eff_dim(height_ff);

   assign req_ready = !sts.busy || sts.finishing;
   assign acc = req_valid && req_ready;
   assign tex_acc = acc && (req_data.operation == ttd_pkg::OP_TEXTURE);
   assign pal_acc = acc && (req_data.operation == ttd_pkg::OP_PALETTE);

   always_comb begin
      case (fmt_ff)
         ttd_pkg::FMT_I4, ttd_pkg::FMT_C4, ttd_pkg::FMT_CMPR: begin
            bw = 4'd8;
            bh = 4'd8;
         end
         ttd_pkg::FMT_I8, ttd_pkg::FMT_IA4, ttd_pkg::FMT_C8: begin
            bw = 4'd8;
            bh = 4'd4;
         end
         default: begin
            bw = 4'd4;
            bh = 4'd4;
         end
      endcase
      last_word = (fmt_ff == ttd_pkg::FMT_RGBA8) ? (wib_ff == 3'd7) : (wib_ff[1:0] == 2'd3);
      col_sum = {1'b0, col_ff} + ttd_pkg::DimW'(bw);
      row_sum = {1'b0, row_ff} + ttd_pkg::DimW'(bh);
      col_in = col_ff;
      row_in = row_ff;
      wib_in = wib_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
         wib_in = '0;
      end else if (tex_acc) begin
         if (last_word) begin
            wib_in = '0;
            if (col_sum >= limit_x) begin
               col_in = '0;
               row_in = (row_sum >= limit_y) ? '0 : row_sum[ttd_pkg::CoordW-1:0];
            end else begin
               col_in = col_sum[ttd_pkg::CoordW-1:0];
            end
         end else begin
            wib_in = wib_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= ttd_pkg::DimW'(1);
         height_ff <= ttd_pkg::DimW'(1);
         fmt_ff <= ttd_pkg::FMT_I4;
         pfmt_ff <= ttd_pkg::PAL_IA8;
         col_ff <= '0;
         row_ff <= '0;
         wib_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         wib_ff <= wib_in;
         if (csr_we) begin
            unique case (csr_index)
               ttd_pkg::CSR_WIDTH:  width_ff <= csr_wdata;
               ttd_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
               ttd_pkg::CSR_FORMAT: fmt_ff <= csr_wdata[3:0];
               ttd_pkg::CSR_PALFMT: pfmt_ff <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tex_acc) begin
         job_ff.word <= req_data.data_word;
         job_ff.ar <= ar_buf_ff[wib_ff[1:0]];
         job_ff.fmt <= fmt_ff;
         job_ff.bx <= col_ff;
         job_ff.by <= row_ff;
         job_ff.wib <= wib_ff;
         job_ff.cmpr <= ttd_pkg::cmpr_palette(req_data.data_word[63:48],
                                              req_data.data_word[47:32]);
         job_ff.limit_x <= limit_x;
         job_ff.limit_y <= limit_y;
         if (fmt_ff == ttd_pkg::FMT_RGBA8 && !wib_ff[2]) begin
            ar_buf_ff[wib_ff[1:0]] <= req_data.data_word;
         end
      end
   end

   for (genvar g = 0; g < ttd_pkg::Lanes; g++) begin : g_lane
      ttd_lane u_lane (
         .job      (job_ff),
         .lane_num (ttd_pkg::LaneW'(g)),
         .lane     (lanes[g])
      );
   end

   always_comb begin
      ctl.load = tex_acc;
      ctl.pal_we = pal_acc;
      ctl.pal_idx = req_data.entry_index;
      ctl.pal_val = req_data.entry_value;
      ctl.pal_fmt = pfmt_ff;
   end

   ttd_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .lanes     (lanes),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
